// ----- hdl/ctf_pkg.sv -----
// shared types, constants and helpers for the complementary tilt filter
package ctf_pkg;

  localparam int DataW  = 32;  // q16.16 angles, rates, integrals
  localparam int GainW  = 16;  // q0.16 gains and time step
  localparam int WideW  = 36;  // working width of intermediate terms
  localparam int SumW   = WideW + 1;
  localparam int CoefW  = GainW + 2;  // signed multiplier coefficient
  localparam int ProdW  = WideW + CoefW;
  localparam int FracW  = 16;
  localparam int InW    = 4 * DataW + GainW;
  localparam int OutW   = 2 * DataW;
  localparam int CfgAddrW = 4;

  // register indices on the configuration port
  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_GAIN  = 2'd1;
  localparam logic [1:0] REG_TC    = 2'd2;

  localparam logic [GainW-1:0] GAIN_RST = 16'd61604;
  localparam logic [GainW-1:0] TC_RST   = 16'd6554;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F_GYR, ST_F_SUM, ST_F_BLG, ST_F_MOV, ST_F_BLA, ST_F_WR,
    ST_S_DIF, ST_S_P1, ST_S_P2, ST_S_P3, ST_S_WRI, ST_S_P4,
    ST_S_T1, ST_S_T2, ST_S_P5, ST_S_WRA,
    ST_DONE
  } ctf_state_t;

  typedef enum logic [2:0] {MA_GYRO, MA_ACC, MA_PROD, MA_HOLD, MA_ACCEL} mul_a_sel_t;
  typedef enum logic [2:0] {MB_DT, MB_GAIN, MB_GAIN_C, MB_TC, MB_TC2} mul_b_sel_t;
  typedef enum logic [2:0] {AX_ACC, AX_PROD, AX_ANGLE, AX_INTEG, AX_ACCEL} add_x_sel_t;
  typedef enum logic [1:0] {AY_ZERO, AY_PROD, AY_GYRO, AY_ANGLE} add_y_sel_t;
  typedef enum logic [1:0] {DS_ACC, DS_HOLD, DS_ANGLE, DS_INTEG} dest_sel_t;

  typedef struct packed {
    logic       load;
    logic       axis;
    logic       mul_en;
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    logic       add_en;
    add_x_sel_t add_x;
    add_y_sel_t add_y;
    logic       add_sub;
    dest_sel_t  dest;
  } ctf_ctrl_t;

  typedef struct packed {
    logic idle;
    logic load_out;
  } ctf_status_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(signed'({1'b0, {(DataW-1){1'b1}}}));
    lo = SumW'(signed'({1'b1, {(DataW-1){1'b0}}}));
    if (v > hi) begin
      return hi[DataW-1:0];
    end else if (v < lo) begin
      return lo[DataW-1:0];
    end
    return v[DataW-1:0];
  endfunction

endpackage

// ----- hdl/complementary_tilt_filter_core.sv -----
// top level of the two-axis complementary tilt filter with its register port
//
// Two-axis complementary tilt filter. Each input beat carries the X and Y
// accelerometer tilt angles, the X and Y gyro rates (all signed q16.16) and
// the time step dt (unsigned q0.16); each produces one output beat with both
// fused angles. order_mode selects the first-order blend (gain blend_gain)
// or the second-order filter (time constant time_constant, with one
// integral term per axis). Products are floored, the stored angles and
// integrals saturate to 32 bits. All arithmetic runs on one shared 36x18
// multiplier and one 37-bit adder under a step sequencer, axis X then Y,
// one operation per cycle. An item occupies the block from acceptance
// through six steps per axis in first-order mode and ten in second-order
// mode, all on the shared multiplier and adder; the input is not ready
// meanwhile. The result waits in an output register, so a new beat is
// taken while the last one is unread; the following result holds in the
// final step until that register frees. Write configuration only while
// the block is idle.
module complementary_tilt_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // accel_x_angle, accel_y_angle, rate_x, rate_y, step_time
  input  logic [ctf_pkg::InW-1:0]        in_tdata,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // angle_x_out, angle_y_out
  output logic [ctf_pkg::OutW-1:0]       out_tdata,
  // register port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ctf_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  localparam int GW = ctf_pkg::GainW;

  logic                    order_mode_r;
  logic [GW-1:0]           blend_gain_r;
  logic [GW-1:0]           time_constant_r;
  logic [1:0]              reg_idx;
  logic                    cfg_wr;

  ctf_pkg::ctf_ctrl_t      ctrl;
  ctf_pkg::ctf_status_t    status;
  logic                    in_accept;
  logic                    out_free;
  logic signed [ctf_pkg::DataW-1:0] angle_x, angle_y;

  logic                    out_tvalid_r;
  logic [ctf_pkg::OutW-1:0] out_tdata_r;

  // register port, always ready, word addressed
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r    <= 1'b0;
      blend_gain_r    <= ctf_pkg::GAIN_RST;
      time_constant_r <= ctf_pkg::TC_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ctf_pkg::REG_ORDER: order_mode_r    <= cfg_pwdata[0];
        ctf_pkg::REG_GAIN:  blend_gain_r    <= cfg_pwdata[GW-1:0];
        ctf_pkg::REG_TC:    time_constant_r <= cfg_pwdata[GW-1:0];
        default: ; // unused address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ctf_pkg::REG_ORDER: cfg_prdata = 32'(order_mode_r);
      ctf_pkg::REG_GAIN:  cfg_prdata = 32'(blend_gain_r);
      ctf_pkg::REG_TC:    cfg_prdata = 32'(time_constant_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // handshake: ready only while the sequencer is idle
  assign in_tready = status.idle;
  assign in_accept = in_tvalid & in_tready;
  // output register free when empty or being read this cycle
  assign out_free  = ~out_tvalid_r | out_tready;

  ctf_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_accept),
    .order_mode (order_mode_r),
    .out_free   (out_free),
    .ctrl       (ctrl),
    .status     (status)
  );

  ctf_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_data       (in_tdata),
    .blend_gain    (blend_gain_r),
    .time_constant (time_constant_r),
    .angle_x       (angle_x),
    .angle_y       (angle_y)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (status.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.load_out) begin
      out_tdata_r <= {angle_y, angle_x};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // an accepted beat keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("input ready right after an accepted beat");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    status.load_out |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten while full");

  // a new result only follows the final sequencer step
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(status.load_out))
    else $error("output valid raised without a finished item");

  // loading the input registers only happens from idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |-> status.idle)
    else $error("input captured while busy");

endmodule

// ----- hdl/ctf_seq.sv -----
// step sequencer driving the shared multiply and add unit
module ctf_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 order_mode,
  input  logic                 out_free,
  output ctf_pkg::ctf_ctrl_t   ctrl,
  output ctf_pkg::ctf_status_t status
);

  ctf_pkg::ctf_state_t state_r, state_nxt;
  logic                axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctf_pkg::ST_IDLE;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      ctf_pkg::ST_IDLE: begin
        axis_nxt = 1'b0;
        if (start) begin
          state_nxt = order_mode ? ctf_pkg::ST_S_DIF : ctf_pkg::ST_F_GYR;
        end
      end
      ctf_pkg::ST_F_GYR: state_nxt = ctf_pkg::ST_F_SUM;
      ctf_pkg::ST_F_SUM: state_nxt = ctf_pkg::ST_F_BLG;
      ctf_pkg::ST_F_BLG: state_nxt = ctf_pkg::ST_F_MOV;
      ctf_pkg::ST_F_MOV: state_nxt = ctf_pkg::ST_F_BLA;
      ctf_pkg::ST_F_BLA: state_nxt = ctf_pkg::ST_F_WR;
      ctf_pkg::ST_F_WR: begin
        axis_nxt  = 1'b1;
        state_nxt = axis_r ? ctf_pkg::ST_DONE : ctf_pkg::ST_F_GYR;
      end
      ctf_pkg::ST_S_DIF: state_nxt = ctf_pkg::ST_S_P1;
      ctf_pkg::ST_S_P1:  state_nxt = ctf_pkg::ST_S_P2;
      ctf_pkg::ST_S_P2:  state_nxt = ctf_pkg::ST_S_P3;
      ctf_pkg::ST_S_P3:  state_nxt = ctf_pkg::ST_S_WRI;
      ctf_pkg::ST_S_WRI: state_nxt = ctf_pkg::ST_S_P4;
      ctf_pkg::ST_S_P4:  state_nxt = ctf_pkg::ST_S_T1;
      ctf_pkg::ST_S_T1:  state_nxt = ctf_pkg::ST_S_T2;
      ctf_pkg::ST_S_T2:  state_nxt = ctf_pkg::ST_S_P5;
      ctf_pkg::ST_S_P5:  state_nxt = ctf_pkg::ST_S_WRA;
      ctf_pkg::ST_S_WRA: begin
        axis_nxt  = 1'b1;
        state_nxt = axis_r ? ctf_pkg::ST_DONE : ctf_pkg::ST_S_DIF;
      end
      ctf_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ctf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ctf_pkg::ST_IDLE;
    endcase
  end

  // step controls
  always_comb begin
    ctrl.load    = 1'b0;
    ctrl.axis    = axis_r;
    ctrl.mul_en  = 1'b0;
    ctrl.mul_a   = ctf_pkg::MA_GYRO;
    ctrl.mul_b   = ctf_pkg::MB_DT;
    ctrl.add_en  = 1'b0;
    ctrl.add_x   = ctf_pkg::AX_ACC;
    ctrl.add_y   = ctf_pkg::AY_ZERO;
    ctrl.add_sub = 1'b0;
    ctrl.dest    = ctf_pkg::DS_ACC;
    status.idle     = 1'b0;
    status.load_out = 1'b0;
    unique case (state_r)
      ctf_pkg::ST_IDLE: begin
        status.idle = 1'b1;
        ctrl.load   = start;
      end
      ctf_pkg::ST_F_GYR: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = ctf_pkg::MA_GYRO;
        ctrl.mul_b  = ctf_pkg::MB_DT;
      end
      ctf_pkg::ST_F_SUM: begin
        ctrl.add_en = 1'b1;
        ctrl.add_x  = ctf_pkg::AX_ANGLE;
        ctrl.add_y  = ctf_pkg::AY_PROD;
        ctrl.dest   = ctf_pkg::DS_ACC;
      end
      ctf_pkg::ST_F_BLG: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = ctf_pkg::MA_ACC;
        ctrl.mul_b  = ctf_pkg::MB_GAIN;
      end
      ctf_pkg::ST_F_MOV: begin
        ctrl.add_en = 1'b1;
        ctrl.add_x  = ctf_pkg::AX_PROD;
        ctrl.add_y  = ctf_pkg::AY_ZERO;
        ctrl.dest   = ctf_pkg::DS_ACC;
      end
      ctf_pkg::ST_F_BLA: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = ctf_pkg::MA_ACCEL;
        ctrl.mul_b  = ctf_pkg::MB_GAIN_C;
      end
      ctf_pkg::ST_F_WR: begin
        ctrl.add_en = 1'b1;
        ctrl.add_x  = ctf_pkg::AX_ACC;
        ctrl.add_y  = ctf_pkg::AY_PROD;
        ctrl.dest   = ctf_pkg::DS_ANGLE;
      end
      ctf_pkg::ST_S_DIF: begin
        ctrl.add_en  = 1'b1;
        ctrl.add_x   = ctf_pkg::AX_ACCEL;
        ctrl.add_y   = ctf_pkg::AY_ANGLE;
        ctrl.add_sub = 1'b1;
        ctrl.dest    = ctf_pkg::DS_HOLD;
      end
      ctf_pkg::ST_S_P1: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = ctf_pkg::MA_HOLD;
        ctrl.mul_b  = ctf_pkg::MB_TC;
      end
      ctf_pkg::ST_S_P2: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = ctf_pkg::MA_PROD;
        ctrl.mul_b  = ctf_pkg::MB_TC;
      end
      ctf_pkg::ST_S_P3: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = ctf_pkg::MA_PROD;
        ctrl.mul_b  = ctf_pkg::MB_DT;
      end
      ctf_pkg::ST_S_WRI: begin
        ctrl.add_en = 1'b1;
        ctrl.add_x  = ctf_pkg::AX_INTEG;
        ctrl.add_y  = ctf_pkg::AY_PROD;
        ctrl.dest   = ctf_pkg::DS_INTEG;
      end
      ctf_pkg::ST_S_P4: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = ctf_pkg::MA_HOLD;
        ctrl.mul_b  = ctf_pkg::MB_TC2;
      end
      ctf_pkg::ST_S_T1: begin
        ctrl.add_en = 1'b1;
        ctrl.add_x  = ctf_pkg::AX_INTEG;
        ctrl.add_y  = ctf_pkg::AY_PROD;
        ctrl.dest   = ctf_pkg::DS_ACC;
      end
      ctf_pkg::ST_S_T2: begin
        ctrl.add_en = 1'b1;
        ctrl.add_x  = ctf_pkg::AX_ACC;
        ctrl.add_y  = ctf_pkg::AY_GYRO;
        ctrl.dest   = ctf_pkg::DS_ACC;
      end
      ctf_pkg::ST_S_P5: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_a  = ctf_pkg::MA_ACC;
        ctrl.mul_b  = ctf_pkg::MB_DT;
      end
      ctf_pkg::ST_S_WRA: begin
        ctrl.add_en = 1'b1;
        ctrl.add_x  = ctf_pkg::AX_ANGLE;
        ctrl.add_y  = ctf_pkg::AY_PROD;
        ctrl.dest   = ctf_pkg::DS_ANGLE;
      end
      ctf_pkg::ST_DONE: begin
        status.load_out = out_free;
      end
      default: begin
        ctrl.load = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/ctf_dpath.sv -----
// shared multiplier and adder with the filter state registers
module ctf_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ctf_pkg::ctf_ctrl_t               ctrl,
  input  logic [ctf_pkg::InW-1:0]          in_data,
  input  logic [ctf_pkg::GainW-1:0]        blend_gain,
  input  logic [ctf_pkg::GainW-1:0]        time_constant,
  output logic signed [ctf_pkg::DataW-1:0] angle_x,
  output logic signed [ctf_pkg::DataW-1:0] angle_y
);

  localparam int DW = ctf_pkg::DataW;
  localparam int WW = ctf_pkg::WideW;
  localparam int SW = ctf_pkg::SumW;
  localparam int GW = ctf_pkg::GainW;
  localparam int CW = ctf_pkg::CoefW;
  localparam int PW = ctf_pkg::ProdW;
  localparam int FW = ctf_pkg::FracW;

  logic signed [DW-1:0] accel_x_r, accel_y_r, gyro_x_r, gyro_y_r;
  logic [GW-1:0]        dt_r;
  logic signed [DW-1:0] angle_x_r, angle_y_r, integ_x_r, integ_y_r;
  logic signed [WW-1:0] acc_r, prod_r, hold_r;

  logic signed [DW-1:0] accel_s, gyro_s, angle_s, integ_s;
  logic signed [WW-1:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [PW-1:0] mul_full;
  logic signed [WW-1:0] prod_nxt;
  logic signed [SW-1:0] add_x, add_y, sum;
  logic signed [DW-1:0] sat_val;

  // input beat capture
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      accel_x_r <= in_data[DW-1:0];
      accel_y_r <= in_data[2*DW-1:DW];
      gyro_x_r  <= in_data[3*DW-1:2*DW];
      gyro_y_r  <= in_data[4*DW-1:3*DW];
      dt_r      <= in_data[4*DW+GW-1:4*DW];
    end
  end

  assign accel_s = ctrl.axis ? accel_y_r : accel_x_r;
  assign gyro_s  = ctrl.axis ? gyro_y_r  : gyro_x_r;
  assign angle_s = ctrl.axis ? angle_y_r : angle_x_r;
  assign integ_s = ctrl.axis ? integ_y_r : integ_x_r;

  always_comb begin
    unique case (ctrl.mul_a)
      ctf_pkg::MA_GYRO:  mul_a = WW'(gyro_s);
      ctf_pkg::MA_ACC:   mul_a = acc_r;
      ctf_pkg::MA_PROD:  mul_a = prod_r;
      ctf_pkg::MA_HOLD:  mul_a = hold_r;
      ctf_pkg::MA_ACCEL: mul_a = WW'(accel_s);
      default:           mul_a = acc_r;
    endcase
  end

  // coefficient in q0.16, one minus gain and twice tc need seventeen bits
  always_comb begin
    unique case (ctrl.mul_b)
      ctf_pkg::MB_DT:     mul_b = CW'(dt_r);
      ctf_pkg::MB_GAIN:   mul_b = CW'(blend_gain);
      ctf_pkg::MB_GAIN_C: mul_b = CW'({1'b1, {GW{1'b0}}}) - CW'(blend_gain);
      ctf_pkg::MB_TC:     mul_b = CW'(time_constant);
      ctf_pkg::MB_TC2:    mul_b = CW'({time_constant, 1'b0});
      default:            mul_b = CW'(dt_r);
    endcase
  end

  // floor of the q0.16 product, the result always fits the working width
  assign mul_full = mul_a * mul_b;
  assign prod_nxt = mul_full[WW+FW-1:FW];

  always_comb begin
    unique case (ctrl.add_x)
      ctf_pkg::AX_ACC:   add_x = SW'(acc_r);
      ctf_pkg::AX_PROD:  add_x = SW'(prod_r);
      ctf_pkg::AX_ANGLE: add_x = SW'(angle_s);
      ctf_pkg::AX_INTEG: add_x = SW'(integ_s);
      ctf_pkg::AX_ACCEL: add_x = SW'(accel_s);
      default:           add_x = SW'(acc_r);
    endcase
  end

  always_comb begin
    unique case (ctrl.add_y)
      ctf_pkg::AY_ZERO:  add_y = '0;
      ctf_pkg::AY_PROD:  add_y = SW'(prod_r);
      ctf_pkg::AY_GYRO:  add_y = SW'(gyro_s);
      ctf_pkg::AY_ANGLE: add_y = SW'(angle_s);
      default:           add_y = '0;
    endcase
  end

  assign sum     = ctrl.add_sub ? (add_x - add_y) : (add_x + add_y);
  assign sat_val = ctf_pkg::sat32(sum);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.add_en && ctrl.dest == ctf_pkg::DS_ACC) begin
      acc_r <= sum[WW-1:0];
    end
    if (ctrl.add_en && ctrl.dest == ctf_pkg::DS_HOLD) begin
      hold_r <= sum[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r <= '0;
      angle_y_r <= '0;
      integ_x_r <= '0;
      integ_y_r <= '0;
    end else if (ctrl.add_en) begin
      if (ctrl.dest == ctf_pkg::DS_ANGLE) begin
        if (ctrl.axis) begin
          angle_y_r <= sat_val;
        end else begin
          angle_x_r <= sat_val;
        end
      end
      if (ctrl.dest == ctf_pkg::DS_INTEG) begin
        if (ctrl.axis) begin
          integ_y_r <= sat_val;
        end else begin
          integ_x_r <= sat_val;
        end
      end
    end
  end

  assign angle_x = angle_x_r;
  assign angle_y = angle_y_r;

endmodule
